### rtl/acds_pkg.sv
// shared constants, register index codes, tan rom and output saturation
// for the ackermann differential speed block
// no dependencies
package acds_pkg;

  localparam int TAN_TABLE_DEPTH   = 90;
  localparam int TAN_FRACTION_BITS = 12;

  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 3;

  // register index codes
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN   = 3'd5;

  // register reset values
  localparam logic [7:0]        RST_WHEEL_BASE = 8'd15;
  localparam logic [DATA_W-1:0] RST_STEER_GAIN = 16'd256;
  localparam logic [DATA_W-1:0] RST_ANGLE_GAIN = 16'd64;
  localparam logic [DATA_W-1:0] RST_SPEED_GAIN = 16'd44;
  localparam logic [DATA_W-1:0] RST_RATE_GAIN  = 16'd23;

  // track widths by sensor mode
  localparam int WIDTH_W = 5;
  localparam logic [WIDTH_W-1:0] WIDTH_CAMERA = 5'd25;
  localparam logic [WIDTH_W-1:0] WIDTH_EM     = 5'd15;

  localparam int MAX_WHEEL_DEG = 89;
  localparam int MAX_DEG = (TAN_TABLE_DEPTH - 1 < MAX_WHEEL_DEG) ?
                           TAN_TABLE_DEPTH - 1 : MAX_WHEEL_DEG;
  localparam int DEG_W = $clog2(TAN_TABLE_DEPTH);

  // tan(89 deg) is below 64, so six integer bits
  localparam int TAN_W = TAN_FRACTION_BITS + 6;
  localparam int NUM_W = 8 + TAN_FRACTION_BITS;
  // wheel_base << F plus 25 * tan stays below 2^(F+11)
  localparam int DEN_W = TAN_FRACTION_BITS + 11;

  // reduced target in q16.16, magnitude at most 2^33
  localparam int E_W    = 35;
  localparam int EMAG_W = 34;
  localparam int IP_W   = EMAG_W - 16;
  localparam int LO_W   = (EMAG_W + 1) / 2;
  localparam int HI_W   = EMAG_W - LO_W;

  localparam int MUL_A_W = (LO_W > DATA_W) ? LO_W : DATA_W;
  localparam int MUL_B_W = NUM_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int PROD_W  = EMAG_W + NUM_W;

  localparam longint RAD_PER_DEG_Q28 = 64'sd4685083;
  localparam int     SERIES_TERMS    = 12;

  typedef logic [TAN_TABLE_DEPTH-1:0][TAN_W-1:0] tan_rom_t;

  // bit-serial unsigned division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tan in q(TAN_FRACTION_BITS) from q28 taylor series of sin and cos
  function automatic tan_rom_t build_tan_rom();
    tan_rom_t    rom;
    longint      x;
    longint      x2;
    longint      ts;
    longint      tc;
    longint      s;
    longint      c;
    logic [63:0] q;
    rom = '0;
    for (int deg = 0; deg < TAN_TABLE_DEPTH; deg++) begin
      x  = longint'(deg) * RAD_PER_DEG_Q28;
      x2 = (x * x) >>> 28;
      ts = x;
      tc = longint'(1) <<< 28;
      s  = ts;
      c  = tc;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
        ts = longint'(udiv64(64'((ts * x2) >>> 28), 64'((2 * k) * (2 * k + 1))));
        tc = longint'(udiv64(64'((tc * x2) >>> 28), 64'((2 * k - 1) * (2 * k))));
        if (k[0]) begin
          s = s - ts;
          c = c - tc;
        end else begin
          s = s + ts;
          c = c + tc;
        end
      end
      if (s < 0) s = 0;
      if (c < 1) c = 1;
      q = udiv64((64'(s) << TAN_FRACTION_BITS) + (64'(c) >> 1), 64'(c));
      rom[deg] = q[TAN_W-1:0];
    end
    return rom;
  endfunction

  localparam tan_rom_t TAN_ROM = build_tan_rom();

  // q16.16 magnitude and sign to saturated 16-bit integer, truncating toward zero
  function automatic logic [DATA_W-1:0] sat_out(input logic [EMAG_W-1:0] m, input logic neg);
    logic [IP_W-1:0] ip;
    ip = m[EMAG_W-1:16];
    if (neg) begin
      if (ip > IP_W'(32768)) return 16'h8000;
      return ~ip[DATA_W-1:0] + 16'd1;
    end
    if (ip > IP_W'(32767)) return 16'h7fff;
    return ip[DATA_W-1:0];
  endfunction

endpackage

### rtl/acds_ifs.sv
// valid/ready channel interfaces: steering input, wheel speed output, register writes
// depends on acds_pkg
interface acds_in_if;
  import acds_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] steer_angle;
  logic signed [DATA_W-1:0] target_speed;

  modport source (output valid, output steer_angle, output target_speed, input ready);
  modport sink   (input valid, input steer_angle, input target_speed, output ready);
endinterface

interface acds_out_if;
  import acds_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] left_speed;
  logic signed [DATA_W-1:0] right_speed;

  modport source (output valid, output left_speed, output right_speed, input ready);
  modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

interface acds_cfg_if;
  import acds_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ackermann_differential_speed.sv
// top level of the ackermann differential wheel speed block
// depends on acds_pkg, acds_ifs (channel interfaces) and acds_div
//
// Each input beat carries a Q8.8 steering command and a signed target speed and
// yields one output beat with left and right wheel speed targets. The block works
// on one beat at a time: after a beat is taken, in ready stays low until the result
// beat has been taken on the output. A single 17 x 20 bit multiplier is stepped
// through seven passes (wheel angle, scaled angle, two speed reduction products,
// track width times tan, and the two halves of the inner wheel numerator), then a
// restoring divider produces one quotient bit per cycle. A beat with a zero wheel
// angle skips the divide and goes from the last pass straight to the output. Tan
// comes from a 90 entry constant table built at elaboration. The config port is
// always ready; registers should be written only while no beat is in flight.
module ackermann_differential_speed (
  input  logic        clk,
  input  logic        rst_n,
  acds_in_if.sink     in_bus,
  acds_out_if.source  out_bus,
  acds_cfg_if.sink    cfg_bus
);
  import acds_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // multiplier passes
  localparam logic [2:0] STEP_DEG    = 3'd0;
  localparam logic [2:0] STEP_SCALE  = 3'd1;
  localparam logic [2:0] STEP_SPEED  = 3'd2;
  localparam logic [2:0] STEP_RATE   = 3'd3;
  localparam logic [2:0] STEP_TAN    = 3'd4;
  localparam logic [2:0] STEP_NUM_LO = 3'd5;
  localparam logic [2:0] STEP_NUM_HI = 3'd6;

  // config registers
  logic              sensor_mode_r;
  logic [7:0]        wheel_base_r;
  logic [DATA_W-1:0] steer_gain_r;
  logic [DATA_W-1:0] angle_gain_r;
  logic [DATA_W-1:0] speed_gain_r;
  logic [DATA_W-1:0] rate_gain_r;

  // control
  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic [2:0] step_r;
  logic [2:0] step_nxt;
  logic       in_fire;
  logic       out_fire;
  logic       finish;
  logic       div_start;
  logic       div_done;

  // datapath
  logic signed [DATA_W-1:0] steer_r;
  logic signed [DATA_W-1:0] speed_cmd_r;
  logic [DATA_W-1:0]        mag_r;
  logic [DATA_W-1:0]        in_mag;
  logic [DEG_W-1:0]         deg_r;
  logic [DEG_W-1:0]         deg_nxt;
  logic [DATA_W-1:0]        deg_raw;
  logic [DATA_W-2:0]        smag_r;
  logic [DATA_W-2:0]        smag_nxt;
  logic [23:0]              smag_raw;
  logic signed [DATA_W-1:0] prev_r;
  logic [DATA_W-1:0]        pmag;
  logic                     s_neg;
  logic                     p_neg;
  logic                     opposite;
  logic signed [17:0]       diff_s;
  logic [DATA_W-1:0]        diff_mag_r;
  logic                     diff_neg_r;
  logic signed [E_W-1:0]    acc_r;
  logic signed [E_W-1:0]    target_q;
  logic signed [E_W-1:0]    prod_e;
  logic [TAN_W-1:0]         tan_r;
  logic [DEN_W-1:0]         den_r;
  logic [NUM_W-1:0]         num;
  logic [WIDTH_W-1:0]       track_w;
  logic [EMAG_W-1:0]        emag_r;
  logic                     e_neg_r;
  logic [PROD_W-1:0]        prod_r;
  logic [PROD_W-1:0]        dividend;
  logic [EMAG_W-1:0]        div_quot;
  logic [EMAG_W-1:0]        inner_mag;
  logic [DATA_W-1:0]        inner_val;
  logic [DATA_W-1:0]        outer_val;
  logic [DATA_W-1:0]        left_r;
  logic [DATA_W-1:0]        right_r;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_bus.valid && out_bus.ready;

  assign in_bus.ready      = (state_r == ST_IDLE);
  assign out_bus.valid     = (state_r == ST_OUT);
  assign out_bus.left_speed  = left_r;
  assign out_bus.right_speed = right_r;
  assign cfg_bus.ready     = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_mode_r <= 1'b0;
      wheel_base_r  <= RST_WHEEL_BASE;
      steer_gain_r  <= RST_STEER_GAIN;
      angle_gain_r  <= RST_ANGLE_GAIN;
      speed_gain_r  <= RST_SPEED_GAIN;
      rate_gain_r   <= RST_RATE_GAIN;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.index)
        REG_SENSOR_MODE: sensor_mode_r <= cfg_bus.data[0];
        REG_WHEEL_BASE:  wheel_base_r  <= cfg_bus.data[7:0];
        REG_STEER_GAIN:  steer_gain_r  <= cfg_bus.data;
        REG_ANGLE_GAIN:  angle_gain_r  <= cfg_bus.data;
        REG_SPEED_GAIN:  speed_gain_r  <= cfg_bus.data;
        REG_RATE_GAIN:   rate_gain_r   <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  assign num     = {wheel_base_r, {TAN_FRACTION_BITS{1'b0}}};
  assign track_w = sensor_mode_r ? WIDTH_CAMERA : WIDTH_EM;

  // steering magnitude, full negative value maps to 0x8000
  assign in_mag = in_bus.steer_angle[DATA_W-1] ?
                  (~in_bus.steer_angle + 16'd1) : in_bus.steer_angle;

  // operand select per pass
  always_comb begin
    case (step_r)
      STEP_DEG: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = MUL_B_W'(steer_gain_r);
      end
      STEP_SCALE: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = MUL_B_W'(angle_gain_r);
      end
      STEP_SPEED: begin
        mul_a = MUL_A_W'(smag_r);
        mul_b = MUL_B_W'(speed_gain_r);
      end
      STEP_RATE: begin
        mul_a = MUL_A_W'(diff_mag_r);
        mul_b = MUL_B_W'(rate_gain_r);
      end
      STEP_TAN: begin
        mul_a = MUL_A_W'(track_w);
        mul_b = MUL_B_W'(tan_r);
      end
      STEP_NUM_LO: begin
        mul_a = MUL_A_W'(emag_r[LO_W-1:0]);
        mul_b = num;
      end
      STEP_NUM_HI: begin
        mul_a = MUL_A_W'(emag_r[EMAG_W-1:LO_W]);
        mul_b = num;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // whole-degree wheel angle, clamped to the table
  always_comb begin
    deg_raw = prod[31:16];
    deg_nxt = (deg_raw > DATA_W'(MAX_DEG)) ? DEG_W'(MAX_DEG) : deg_raw[DEG_W-1:0];
  end

  // scaled angle magnitude, clamped to 15 bits
  always_comb begin
    smag_raw = prod[31:8];
    smag_nxt = (|smag_raw[23:15]) ? 15'h7fff : smag_raw[14:0];
  end

  // change of scaled magnitude against the previous tick; a zero on either side
  // counts as the same sign
  always_comb begin
    s_neg    = steer_r[DATA_W-1] && (smag_r != '0);
    p_neg    = prev_r[DATA_W-1];
    pmag     = p_neg ? (~prev_r + 16'd1) : prev_r;
    opposite = (s_neg && !p_neg && (prev_r != '0)) || (!s_neg && (smag_r != '0) && p_neg);
    diff_s   = opposite ? ($signed(18'(smag_r)) + $signed(18'(pmag)))
                        : ($signed(18'(smag_r)) - $signed(18'(pmag)));
  end

  // products feeding the accumulator stay below 2^32
  assign target_q = $signed({{(E_W-32){speed_cmd_r[DATA_W-1]}}, speed_cmd_r, 16'h0000});
  assign prod_e   = $signed({1'b0, prod[E_W-2:0]});

  assign dividend = prod_r + (PROD_W'(prod) << LO_W);

  // sequencer
  assign finish    = ((state_r == ST_MUL) && (step_r == STEP_NUM_HI) && (deg_r == '0)) ||
                     ((state_r == ST_DIV) && div_done);
  assign div_start = (state_r == ST_MUL) && (step_r == STEP_NUM_HI) && (deg_r != '0);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
          step_nxt  = STEP_DEG;
        end
      end
      ST_MUL: begin
        if (step_r == STEP_NUM_HI) begin
          state_nxt = (deg_r == '0) ? ST_OUT : ST_DIV;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_DEG;
      prev_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      // previous scaled angle is replaced once its change has been taken
      if ((state_r == ST_MUL) && (step_r == STEP_SPEED)) begin
        prev_r <= s_neg ? $signed(~{1'b0, smag_r} + 16'd1) : $signed({1'b0, smag_r});
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      steer_r     <= in_bus.steer_angle;
      speed_cmd_r <= in_bus.target_speed;
      mag_r       <= in_mag;
    end
    if (state_r == ST_MUL) begin
      case (step_r)
        STEP_DEG:   deg_r  <= deg_nxt;
        STEP_SCALE: smag_r <= smag_nxt;
        STEP_SPEED: begin
          acc_r      <= target_q - prod_e;
          diff_neg_r <= diff_s[17];
          diff_mag_r <= diff_s[17] ? DATA_W'(-diff_s) : diff_s[DATA_W-1:0];
          tan_r      <= TAN_ROM[deg_r];
        end
        STEP_RATE: acc_r <= diff_neg_r ? (acc_r + prod_e) : (acc_r - prod_e);
        STEP_TAN: begin
          den_r   <= DEN_W'(num) + prod[DEN_W-1:0];
          e_neg_r <= acc_r[E_W-1];
          emag_r  <= acc_r[E_W-1] ? EMAG_W'(-acc_r) : acc_r[EMAG_W-1:0];
        end
        STEP_NUM_LO: prod_r <= PROD_W'(prod);
        default: ;
      endcase
    end
    if (finish) begin
      left_r  <= (!steer_r[DATA_W-1] && (steer_r != '0)) ? inner_val : outer_val;
      right_r <= steer_r[DATA_W-1] ? inner_val : outer_val;
    end
  end

  // inner wheel: reduced target unless the wheel angle is nonzero
  assign inner_mag = (deg_r == '0) ? emag_r : div_quot;
  assign inner_val = sat_out(inner_mag, e_neg_r);
  assign outer_val = sat_out(emag_r, e_neg_r);

  acds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_bus.ready)
    else $error("input taken while a beat is in flight");

  a_prev_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    prev_r != 16'sh8000)
    else $error("previous scaled angle out of range");

  a_ratio_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> div_quot <= emag_r)
    else $error("inner wheel faster than outer wheel");

  a_div_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (deg_r != '0) && (deg_r <= DEG_W'(MAX_DEG)))
    else $error("divide entered with a bad wheel angle");

endmodule

### rtl/acds_div.sv
// restoring divider, one quotient bit per cycle, for the inner wheel ratio
// depends on acds_pkg
module acds_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [acds_pkg::PROD_W-1:0]  dividend,
  input  logic [acds_pkg::DEN_W-1:0]   divisor,
  output logic                         done,
  output logic [acds_pkg::EMAG_W-1:0]  quot
);
  import acds_pkg::*;

  localparam int CNT_W = $clog2(EMAG_W);

  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  rem_nxt;
  logic [EMAG_W-1:0] qd_r;
  logic [EMAG_W-1:0] qd_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    trial;
  logic              fits;

  // dividend bits enter from the top of the quotient register
  always_comb begin
    trial   = {rem_r, qd_r[EMAG_W-1]};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    qd_nxt  = {qd_r[EMAG_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(EMAG_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // quotient fits in EMAG_W bits, so the top bits already sit below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(dividend[PROD_W-1:EMAG_W]);
      qd_r  <= dividend[EMAG_W-1:0];
      den_r <= (divisor == '0) ? DEN_W'(1) : divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      qd_r  <= qd_nxt;
    end
  end

  assign done = done_r;
  assign quot = qd_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");

endmodule

### test/ackermann_differential_speed_tb.sv
// self-checking testbench for the ackermann differential wheel speed block
// drives steering beats and register writes and checks wheel beats against its own predictor
// depends on acds_pkg, acds_ifs and the rtl top level ackermann_differential_speed
`timescale 1ns / 100ps

module ackermann_differential_speed_tb;
  import acds_pkg::*;

  // run shape
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int PLAN_ROWS       = 33;
  localparam int WATCHDOG_LIMIT  = 2000;
  // a little more than the slowest beat through the divider
  localparam int DRAIN_CYCLES    = 60;

  // spare register indexes, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  // track widths and the pi/180 constant for the tan table
  localparam longint TRACK_CAMERA = 25;
  localparam longint TRACK_EM     = 15;
  localparam longint RAD_Q28      = 4685083;
  localparam int     TAYLOR_TERMS = 12;

  typedef struct packed {
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
  } wheel_pair_t;

  // one row of the directed plan: either a register write or a steering beat,
  // the latter optionally with a hand-typed wheel result
  typedef struct packed {
    logic                     is_reg;
    logic [CFG_IDX_W-1:0]     idx;
    logic [DATA_W-1:0]        word;
    logic signed [DATA_W-1:0] steer;
    logic signed [DATA_W-1:0] target;
    logic                     known;
    logic signed [DATA_W-1:0] known_left;
    logic signed [DATA_W-1:0] known_right;
  } plan_row_t;

  logic clk;
  logic rst_n;

  acds_in_if  in_if();
  acds_out_if out_if();
  acds_cfg_if cfg_if();

  ackermann_differential_speed dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_if),
    .out_bus(out_if),
    .cfg_bus(cfg_if)
  );

  always #1 clk = ~clk;

  // predictor copy of the registers and of the stored scaled angle
  logic              reg_mode;
  logic [7:0]        reg_wheel_base;
  logic [DATA_W-1:0] reg_steer_gain;
  logic [DATA_W-1:0] reg_angle_gain;
  logic [DATA_W-1:0] reg_speed_gain;
  logic [DATA_W-1:0] reg_rate_gain;
  logic signed [DATA_W-1:0] held_scaled;

  longint tan_lut [0:TAN_TABLE_DEPTH-1];

  // wheel results still owed by the block, oldest first
  wheel_pair_t wheel_q [$];

  // hand-typed result that rides along with the steering beat on the bus
  logic                     pin_known;
  logic signed [DATA_W-1:0] pin_left;
  logic signed [DATA_W-1:0] pin_right;

  int errors;
  int beats_sent;
  int beats_checked;
  int reg_writes;
  int stalled;
  int idle_pct;
  int stall_left;

  plan_row_t plan [0:PLAN_ROWS-1];

  // tan(deg) in q12: q28 taylor series for sin and cos, rounded quotient
  function automatic longint tan_q(input int deg);
    longint x, x2, ts, tc, sn, cs;
    int k;
    x  = longint'(deg) * RAD_Q28;
    x2 = (x * x) >>> 28;
    ts = x;
    tc = longint'(1) <<< 28;
    sn = ts;
    cs = tc;
    for (k = 1; k <= TAYLOR_TERMS; k++) begin
      ts = ((ts * x2) >>> 28) / longint'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >>> 28) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sn = sn - ts;
        cs = cs - tc;
      end else begin
        sn = sn + ts;
        cs = cs + tc;
      end
    end
    if (sn < 0) sn = 0;
    if (cs < 1) cs = 1;
    return ((sn <<< TAN_FRACTION_BITS) + cs / 2) / cs;
  endfunction

  // q16.16 to a whole wheel speed, truncated toward zero and saturated
  function automatic logic signed [DATA_W-1:0] wheel_int(input longint v);
    longint m;
    m = ((v < 0) ? -v : v) >>> 16;
    if (v < 0) begin
      if (m > 32768) m = 32768;
      return DATA_W'(-m);
    end
    if (m > 32767) m = 32767;
    return DATA_W'(m);
  endfunction

  // wheel speeds for one steering beat, given the stored scaled angle
  function automatic wheel_pair_t predict_wheels(input logic signed [DATA_W-1:0] steer,
                                                 input logic signed [DATA_W-1:0] target,
                                                 input logic signed [DATA_W-1:0] held,
                                                 output logic signed [DATA_W-1:0] scaled);
    longint st, mag, deg, smag, sval, pval, pmag, diff, e, inner, num, den, track;
    wheel_pair_t res;
    st  = steer;
    mag = (st < 0) ? -st : st;
    // whole-degree wheel angle
    deg = (mag * longint'(reg_steer_gain)) >>> 16;
    if (deg > MAX_DEG) deg = MAX_DEG;
    // scaled angle magnitude in q8.8
    smag = (mag * longint'(reg_angle_gain)) >>> 8;
    if (smag > 32767) smag = 32767;
    sval = (st < 0) ? -smag : smag;
    pval = held;
    pmag = (pval < 0) ? -pval : pval;
    // magnitude change, counted across zero when the sign flips
    if ((sval >= 0 && pval >= 0) || (sval <= 0 && pval <= 0)) diff = smag - pmag;
    else diff = smag + pmag;
    e = longint'(target) * 65536 - smag * longint'(reg_speed_gain)
        - diff * longint'(reg_rate_gain);
    inner = e;
    if (deg != 0) begin
      track = reg_mode ? TRACK_CAMERA : TRACK_EM;
      num   = longint'(reg_wheel_base) <<< TAN_FRACTION_BITS;
      den   = num + track * tan_lut[deg];
      if (den == 0) den = 1;
      inner = (((e < 0) ? -e : e) * num) / den;
      if (e < 0) inner = -inner;
    end
    // left is the inner wheel on a left turn
    if (st > 0) begin
      res.left  = wheel_int(inner);
      res.right = wheel_int(e);
    end else if (st < 0) begin
      res.left  = wheel_int(e);
      res.right = wheel_int(inner);
    end else begin
      res.left  = wheel_int(e);
      res.right = wheel_int(e);
    end
    scaled = DATA_W'(sval);
    return res;
  endfunction

  function automatic plan_row_t beat_row(input logic signed [DATA_W-1:0] st,
                                         input logic signed [DATA_W-1:0] sp);
    plan_row_t r;
    r        = '0;
    r.steer  = st;
    r.target = sp;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic signed [DATA_W-1:0] st,
                                          input logic signed [DATA_W-1:0] sp,
                                          input logic signed [DATA_W-1:0] l,
                                          input logic signed [DATA_W-1:0] r_);
    plan_row_t r;
    r             = beat_row(st, sp);
    r.known       = 1'b1;
    r.known_left  = l;
    r.known_right = r_;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [DATA_W-1:0] word);
    plan_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.word   = word;
    return r;
  endfunction

  // mostly modest gains around the defaults, sometimes anything
  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0, 1: return DATA_W'($urandom_range(0, 512));
      2:    return DATA_W'($urandom_range(0, 2048));
      default: return DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // one steering beat, after an optional idle burst; returns at the falling
  // edge after the beat was taken, with valid still high
  task automatic send_cmd(input logic signed [DATA_W-1:0] steer,
                          input logic signed [DATA_W-1:0] target,
                          input logic known,
                          input logic signed [DATA_W-1:0] kl,
                          input logic signed [DATA_W-1:0] kr);
    int gap;
    cfg_if.valid <= 1'b0;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.steer_angle  <= steer;
    in_if.target_speed <= target;
    pin_known          <= known;
    pin_left           <= kl;
    pin_right          <= kr;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // register write once every owed wheel beat is back, so the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] word);
    in_if.valid <= 1'b0;
    while (wheel_q.size() != 0) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= word;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  // result side: random stall bursts, none while idle_pct is zero
  always @(negedge clk) begin
    if (idle_pct != 0 && stall_left == 0 && out_if.ready &&
        $urandom_range(1, 100) <= idle_pct / 2)
      stall_left = $urandom_range(1, 6);
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // everything taken at a rising edge: compare wheel beats, predict steering
  // beats, mirror register writes, and watch for a hung handshake
  always @(posedge clk) begin
    wheel_pair_t got, want, calc;
    logic signed [DATA_W-1:0] next_scaled;
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      // pop before push so a broken same-edge overlap is still caught
      if (out_if.valid && out_if.ready) begin
        moved     = 1'b1;
        got.left  = out_if.left_speed;
        got.right = out_if.right_speed;
        beats_checked++;
        if (wheel_q.size() == 0) begin
          errors++;
          $display("%0t: wheel beat with nothing owed, left %0d right %0d",
                   $time, got.left, got.right);
        end else begin
          want = wheel_q.pop_front();
          if (got.left !== want.left) begin
            errors++;
            $display("%0t: left_speed mismatch, expected %0d, got %0d",
                     $time, want.left, got.left);
          end
          if (got.right !== want.right) begin
            errors++;
            $display("%0t: right_speed mismatch, expected %0d, got %0d",
                     $time, want.right, got.right);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        beats_sent++;
        // predictor always runs so the stored angle stays in step
        calc        = predict_wheels(in_if.steer_angle, in_if.target_speed,
                                     held_scaled, next_scaled);
        held_scaled = next_scaled;
        if (pin_known) begin
          want.left  = pin_left;
          want.right = pin_right;
          wheel_q.push_back(want);
        end else begin
          wheel_q.push_back(calc);
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        reg_writes++;
        // upper bits beyond each register's width are dropped
        case (cfg_if.index)
          REG_SENSOR_MODE: reg_mode       = cfg_if.data[0];
          REG_WHEEL_BASE:  reg_wheel_base = cfg_if.data[7:0];
          REG_STEER_GAIN:  reg_steer_gain = cfg_if.data;
          REG_ANGLE_GAIN:  reg_angle_gain = cfg_if.data;
          REG_SPEED_GAIN:  reg_speed_gain = cfg_if.data;
          REG_RATE_GAIN:   reg_rate_gain  = cfg_if.data;
          default: ;
        endcase
      end
      if (moved) stalled = 0;
      else stalled++;
      if (stalled >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat moved for %0d cycles, %0d wheel beats owed",
                 $time, stalled, wheel_q.size());
        $display("ackermann_differential_speed_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int r, ph, n;
    logic signed [DATA_W-1:0] steer, target, last_steer;
    logic [DATA_W-1:0] mode_w, wb_w, sg_w, ag_w, spg_w, rg_w;
    int sel;

    // every input known from time zero
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.steer_angle   = '0;
    in_if.target_speed  = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_SENSOR_MODE;
    cfg_if.data         = '0;
    out_if.ready        = 1'b0;
    pin_known           = 1'b0;
    pin_left            = '0;
    pin_right           = '0;
    errors              = 0;
    beats_sent          = 0;
    beats_checked       = 0;
    reg_writes          = 0;
    stalled             = 0;
    stall_left          = 0;
    idle_pct            = 25;
    last_steer          = '0;

    // predictor state after reset
    reg_mode       = 1'b0;
    reg_wheel_base = RST_WHEEL_BASE;
    reg_steer_gain = RST_STEER_GAIN;
    reg_angle_gain = RST_ANGLE_GAIN;
    reg_speed_gain = RST_SPEED_GAIN;
    reg_rate_gain  = RST_RATE_GAIN;
    held_scaled    = '0;
    for (r = 0; r < TAN_TABLE_DEPTH; r++) tan_lut[r] = tan_q(r);

    // directed plan; typed results only where they follow from the reset
    // state or from zeroed gains without arithmetic
    plan = '{
      // straight ahead, speed extremes, default registers
      known_row(16'sd0, 16'sd0, 16'sd0, 16'sd0),
      known_row(16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff),
      known_row(16'sd0, 16'sh8000, 16'sh8000, 16'sh8000),
      // a hair of steering rounds to a zero wheel angle and zero scaled angle
      known_row(16'sd1, 16'sd1000, 16'sd1000, 16'sd1000),
      known_row(-16'sd1, -16'sd1000, -16'sd1000, -16'sd1000),
      // steering extremes, then a sign flip across zero
      beat_row(16'sh7fff, 16'sd0),
      beat_row(16'sh8000, 16'sd0),
      beat_row(16'sh0a00, 16'sd5000),
      beat_row(-16'sh0a00, 16'sd5000),
      beat_row(16'sh1e00, -16'sd20000),
      // camera track width
      reg_row(REG_SENSOR_MODE, 16'd1),
      beat_row(16'sh1e00, 16'sd20000),
      // zero wheel base pins the inner wheel to zero
      reg_row(REG_WHEEL_BASE, 16'd0),
      beat_row(16'sh1e00, 16'sd20000),
      beat_row(-16'sh1e00, -16'sd20000),
      // spare indexes are ignored
      reg_row(IDX_SPARE_LO, 16'hffff),
      reg_row(IDX_SPARE_HI, 16'h0000),
      // bits above the register width are dropped
      reg_row(REG_SENSOR_MODE, 16'hfffe),
      reg_row(REG_WHEEL_BASE, 16'hff01),
      beat_row(16'sh2d00, 16'sd12345),
      // all gains at the top
      reg_row(REG_STEER_GAIN, 16'hffff),
      reg_row(REG_ANGLE_GAIN, 16'hffff),
      reg_row(REG_SPEED_GAIN, 16'hffff),
      reg_row(REG_RATE_GAIN, 16'hffff),
      beat_row(16'sh7fff, 16'sh7fff),
      beat_row(16'sh8000, 16'sh8000),
      beat_row(16'sd1, 16'sh7fff),
      // all gains at zero: wheel angle and reductions vanish
      reg_row(REG_STEER_GAIN, 16'h0000),
      reg_row(REG_ANGLE_GAIN, 16'h0000),
      reg_row(REG_SPEED_GAIN, 16'h0000),
      reg_row(REG_RATE_GAIN, 16'h0000),
      known_row(16'sh5a00, 16'sh8000, 16'sh8000, 16'sh8000),
      known_row(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff)
    };

    // synchronous reset, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].is_reg)
        write_reg(plan[r].idx, plan[r].word);
      else
        send_cmd(plan[r].steer, plan[r].target, plan[r].known,
                 plan[r].known_left, plan[r].known_right);
    end
    last_steer = plan[PLAN_ROWS-1].steer;

    // random phases, each under its own register setting
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) begin
        idle_pct = 0;
      end else if (ph == 0) begin
        idle_pct = 30;
      end else begin
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 15;
          2: idle_pct = 35;
          default: idle_pct = 60;
        endcase
      end

      case (ph)
        // the reset setting
        0: begin
          mode_w = 16'd0; wb_w = 16'd15;
          sg_w = RST_STEER_GAIN; ag_w = RST_ANGLE_GAIN;
          spg_w = RST_SPEED_GAIN; rg_w = RST_RATE_GAIN;
        end
        // everything at its top
        1: begin
          mode_w = 16'd1; wb_w = 16'd255;
          sg_w = 16'hffff; ag_w = 16'hffff; spg_w = 16'hffff; rg_w = 16'hffff;
        end
        // zero wheel base with live steering, heavy rate term
        2: begin
          mode_w = 16'd0; wb_w = 16'd0;
          sg_w = 16'd256; ag_w = 16'hffff; spg_w = 16'd0; rg_w = 16'hffff;
        end
        // smallest legal wheel base, no gains at all
        3: begin
          mode_w = 16'd0; wb_w = 16'd1;
          sg_w = 16'd0; ag_w = 16'd0; spg_w = 16'd0; rg_w = 16'd0;
        end
        default: begin
          mode_w = DATA_W'($urandom_range(0, 1));
          wb_w   = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 4))
                                               : DATA_W'($urandom_range(1, 255));
          sg_w   = pick_gain();
          ag_w   = pick_gain();
          spg_w  = pick_gain();
          rg_w   = pick_gain();
        end
      endcase
      write_reg(REG_SENSOR_MODE, mode_w);
      write_reg(REG_WHEEL_BASE, wb_w);
      write_reg(REG_STEER_GAIN, sg_w);
      write_reg(REG_ANGLE_GAIN, ag_w);
      write_reg(REG_SPEED_GAIN, spg_w);
      write_reg(REG_RATE_GAIN, rg_w);

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 15);
        if (sel < 7) begin
          // ordinary turns up to about 50 degrees either way
          steer = DATA_W'($urandom_range(0, 16'h3200));
          if ($urandom_range(0, 1)) steer = -steer;
        end else if (sel < 9) begin
          // held command, so the rate term sees no change
          steer = last_steer;
        end else if (sel < 11) begin
          // right around straight ahead
          steer = DATA_W'($urandom_range(0, 8));
          steer = steer - 16'sd4;
        end else if (sel < 13) begin
          case ($urandom_range(0, 3))
            0: steer = 16'sh7fff;
            1: steer = 16'sh8000;
            2: steer = 16'sh8001;
            default: steer = -last_steer;
          endcase
        end else begin
          steer = DATA_W'($urandom_range(0, 65535));
        end
        if ($urandom_range(0, 3) == 0) target = DATA_W'($urandom_range(0, 65535));
        else begin
          target = DATA_W'($urandom_range(0, 16000));
          target = target - 16'sd8000;
        end
        send_cmd(steer, target, 1'b0, 16'sd0, 16'sd0);
        last_steer = steer;
      end
    end

    // drop the bus and let the last wheel beats come home
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (wheel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d steering beats and %0d wheel beats, %0d register writes",
             beats_sent, beats_checked, reg_writes);
    $display("over %0d register settings plus the directed plan, %0d mismatches",
             PHASES, errors);
    if (errors == 0) begin
      $display("ackermann_differential_speed_tb: done, clean");
    end else begin
      $display("ackermann_differential_speed_tb: done, errors");
    end
    $finish;
  end

endmodule
